[rtl/core/gsi_pkg.sv]
// ----------------------------------------------------------------------------
// gsi_pkg
// Shared types and constants for the Gouraud span interpolator: beat
// structs, sequencer states and fixed-point widths.
// ----------------------------------------------------------------------------
package gsi_pkg;

    localparam int MAX_SPAN   = 64;
    localparam int COORD_BITS = 12;

    localparam int CH_W      = 31;                  // Q1.30 channel input
    localparam int ACC_W     = CH_W + 1;            // signed accumulator / step
    localparam int OUT_SHIFT = 22;
    localparam int OUT_W     = 9;
    localparam int ALPHA_W   = 8;
    localparam int NUM_CH    = 4;
    localparam int CH_IDX_W  = 2;
    localparam int LEN_W     = COORD_BITS + 1;      // signed span length
    localparam int BIT_W     = $clog2(CH_W);        // divider step counter
    localparam int CNT_W     = $clog2(MAX_SPAN + 1);
    localparam int IDX_W     = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

    localparam logic [ALPHA_W-1:0] GLOBAL_ALPHA_RST = 8'd255;

    typedef struct packed {
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] row;
        logic [CH_W-1:0]       red_left;
        logic [CH_W-1:0]       green_left;
        logic [CH_W-1:0]       blue_left;
        logic [CH_W-1:0]       alpha_left;
        logic [CH_W-1:0]       red_right;
        logic [CH_W-1:0]       green_right;
        logic [CH_W-1:0]       blue_right;
        logic [CH_W-1:0]       alpha_right;
    } t_span_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [OUT_W-1:0]      red;
        logic [OUT_W-1:0]      green;
        logic [OUT_W-1:0]      blue;
        logic [OUT_W-1:0]      alpha;
        logic [ALPHA_W-1:0]    painter_alpha;
        logic                  last_pixel;
        logic                  span_clipped;
    } t_pixel_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } t_state;

    localparam logic [CH_IDX_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_IDX_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_IDX_W-1:0] CH_BLUE  = 2'd2;
    localparam logic [CH_IDX_W-1:0] CH_ALPHA = 2'd3;

endpackage

[rtl/core/gouraud_span_interpolator.sv]
// ----------------------------------------------------------------------------
// gouraud_span_interpolator
// Per-span color step division followed by one shaded pixel per clock.
// ----------------------------------------------------------------------------
// A span is taken when start is high and busy is low. The four channel steps
// come from one shared restoring divider, one quotient bit per cycle: each
// channel takes a load step and then its divide steps, and all four finish
// before the first pixel. Pixels then leave one per cycle, each marked by
// o_valid for a single cycle, up to MAX_SPAN of them; the receiver cannot
// stall them. busy stays high until the last emitted pixel has left.
// An empty or reversed span produces nothing and leaves the block idle.
module gouraud_span_interpolator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gsi_pkg::t_span_in             i_span,
    input  logic                          i_cfg_we,
    input  logic [gsi_pkg::ALPHA_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    output gsi_pkg::t_pixel_out           o_pixel
);
    import gsi_pkg::*;

    t_state                r_state, n_state;
    t_span_in              r_span,  n_span;
    logic [ALPHA_W-1:0]    r_galpha;
    logic [COORD_BITS-1:0] r_len,   n_len;
    logic [CNT_W-1:0]      r_cnt,   n_cnt;
    logic                  r_clip,  n_clip;
    logic [IDX_W-1:0]      r_idx,   n_idx;
    logic [CH_IDX_W-1:0]   r_ch,    n_ch;
    logic [BIT_W-1:0]      r_bit,   n_bit;
    logic [COORD_BITS-1:0] r_rem,   n_rem;
    logic [CH_W-1:0]       r_dq,    n_dq;
    logic                  r_neg,   n_neg;
    logic [ACC_W-1:0]      r_acc  [NUM_CH];
    logic [ACC_W-1:0]      n_acc  [NUM_CH];
    logic [ACC_W-1:0]      r_step [NUM_CH];
    logic [ACC_W-1:0]      n_step [NUM_CH];

    logic [LEN_W-1:0]      len_in;
    logic [CH_W-1:0]       ch_l, ch_r;
    logic [ACC_W-1:0]      diff, diff_mag;
    logic [LEN_W-1:0]      trial;

    // operand select for the shared divider
    always_comb begin
        case (r_ch)
            CH_RED: begin
                ch_l = r_span.red_left;
                ch_r = r_span.red_right;
            end
            CH_GREEN: begin
                ch_l = r_span.green_left;
                ch_r = r_span.green_right;
            end
            CH_BLUE: begin
                ch_l = r_span.blue_left;
                ch_r = r_span.blue_right;
            end
            CH_ALPHA: begin
                ch_l = r_span.alpha_left;
                ch_r = r_span.alpha_right;
            end
            default: begin
                ch_l = r_span.red_left;
                ch_r = r_span.red_right;
            end
        endcase
    end

    assign len_in   = {1'b0, i_span.x_end} - {1'b0, i_span.x_start};
    assign diff     = {1'b0, ch_r} - {1'b0, ch_l};
    assign diff_mag = diff[ACC_W-1] ? (~diff + 1'b1) : diff;
    assign trial    = {r_rem, r_dq[CH_W-1]} - {1'b0, r_len};

    always_comb begin
        n_state = r_state;
        n_span  = r_span;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_clip  = r_clip;
        n_idx   = r_idx;
        n_ch    = r_ch;
        n_bit   = r_bit;
        n_rem   = r_rem;
        n_dq    = r_dq;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_step  = r_step;
        busy    = (r_state != ST_IDLE);
        o_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_span = i_span;
                    n_len  = len_in[COORD_BITS-1:0];
                    n_ch   = CH_RED;
                    n_idx  = '0;
                    n_clip = ($signed(len_in) > $signed(LEN_W'(MAX_SPAN)));
                    n_cnt  = n_clip ? CNT_W'(MAX_SPAN) : CNT_W'(len_in);
                    // drop empty or reversed spans
                    if (!len_in[LEN_W-1] && (len_in != '0)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                n_dq   = diff_mag[CH_W-1:0];
                n_neg  = diff[ACC_W-1];
                n_rem  = '0;
                n_bit  = '0;
                n_acc[r_ch] = {1'b0, ch_l};
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!trial[LEN_W-1]) begin
                    n_rem = trial[COORD_BITS-1:0];
                    n_dq  = {r_dq[CH_W-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[COORD_BITS-2:0], r_dq[CH_W-1]};
                    n_dq  = {r_dq[CH_W-2:0], 1'b0};
                end
                n_bit = r_bit + 1'b1;
                if (r_bit == BIT_W'(CH_W - 1)) begin
                    n_step[r_ch] = r_neg ? (~{1'b0, n_dq} + 1'b1) : {1'b0, n_dq};
                    if (r_ch == CH_ALPHA) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_EMIT: begin
                o_valid = 1'b1;
                for (int c = 0; c < NUM_CH; c++) begin
                    n_acc[c] = r_acc[c] + r_step[c];
                end
                n_idx = r_idx + 1'b1;
                if (o_pixel.last_pixel) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pixel.pixel_x       = r_span.x_start + COORD_BITS'(r_idx);
        o_pixel.pixel_y       = r_span.row;
        o_pixel.red           = r_acc[CH_RED][CH_W-1:OUT_SHIFT];
        o_pixel.green         = r_acc[CH_GREEN][CH_W-1:OUT_SHIFT];
        o_pixel.blue          = r_acc[CH_BLUE][CH_W-1:OUT_SHIFT];
        o_pixel.alpha         = r_acc[CH_ALPHA][CH_W-1:OUT_SHIFT];
        o_pixel.painter_alpha = r_galpha;
        o_pixel.last_pixel    = ((CNT_W'(r_idx) + 1'b1) == r_cnt);
        o_pixel.span_clipped  = r_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_galpha <= GLOBAL_ALPHA_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_galpha <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_span <= n_span;
        r_len  <= n_len;
        r_cnt  <= n_cnt;
        r_clip <= n_clip;
        r_idx  <= n_idx;
        r_ch   <= n_ch;
        r_bit  <= n_bit;
        r_rem  <= n_rem;
        r_dq   <= n_dq;
        r_neg  <= n_neg;
        r_acc  <= n_acc;
        r_step <= n_step;
    end

endmodule

[rtl/core/gsi_checker.sv]
// ----------------------------------------------------------------------------
// gsi_checker
// Port-level checks on the span interpolator's pixel beats.
// ----------------------------------------------------------------------------
module gsi_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input gsi_pkg::t_pixel_out           o_pixel
);
    import gsi_pkg::*;

    // pixels leave only while a span is in work
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("pixel beat while idle");

    // no pixel beat comes in the cycle after a span is accepted
    a_no_beat_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("pixel beat right after span accept");

    // beats of one span are back to back, one column apart, same row
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pixel.last_pixel) |=>
            (o_valid &&
             (o_pixel.pixel_x == COORD_BITS'($past(o_pixel.pixel_x) + 1'b1)) &&
             (o_pixel.pixel_y == $past(o_pixel.pixel_y))))
        else $error("span beats not contiguous");

    // the last beat ends the span
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel.last_pixel) |=> (!o_valid && !busy))
        else $error("activity after last pixel");

endmodule

bind gouraud_span_interpolator gsi_checker u_gsi_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_pixel (o_pixel)
);
